// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EBV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EBV_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EBV_ASSERT(label, clk, rst, prop, msg)
`define EBV_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== sv/ebv_pkg.sv =====
`default_nettype none
package ebv_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS = 16;
  localparam int STAGES = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int IDX_W = 5;

  localparam int XW = 34;   // cordic x/y, Q2.30 with headroom
  localparam int ZW = 34;   // residual angle
  localparam int TW = 22;   // sin/cos Q2.20
  localparam int PW = 44;   // two-factor product
  localparam int QW = 64;   // Q.60 sum

  localparam logic [31:0] PHASE_KEEP =
    ~(32'((64'd1 << (32 - ANGLE_BITS)) - 64'd1));
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // one item in flight through the rotation chain: pitch, yaw, roll
  typedef struct packed {
    logic            valid;
    rot_t [2:0]      rot;
    logic [2:0][1:0] quad;
  } bundle_t;

  function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ebv_cordic_cell.sv =====
`default_nettype none
module ebv_cordic_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic [ebv_pkg::IDX_W-1:0]    stage,
  input  wire ebv_pkg::bundle_t             din,
  output ebv_pkg::bundle_t                  dout
);
  ebv_pkg::bundle_t             nxt;
  logic signed [ebv_pkg::ZW-1:0] ang;

  always_comb begin
    ang = ebv_pkg::ZW'($signed({1'b0, ebv_pkg::atan_entry(stage)}));
    nxt = din;
    for (int k = 0; k < 3; k++) begin
      if (!din.rot[k].z[ebv_pkg::ZW-1]) begin
        nxt.rot[k].x = din.rot[k].x - (din.rot[k].y >>> stage);
        nxt.rot[k].y = din.rot[k].y + (din.rot[k].x >>> stage);
        nxt.rot[k].z = din.rot[k].z - ang;
      end else begin
        nxt.rot[k].x = din.rot[k].x + (din.rot[k].y >>> stage);
        nxt.rot[k].y = din.rot[k].y - (din.rot[k].x >>> stage);
        nxt.rot[k].z = din.rot[k].z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dout.rot  <= nxt.rot;
      dout.quad <= nxt.quad;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= nxt.valid;
    end
  end
endmodule
`default_nettype wire

// ===== sv/ebv_combine.sv =====
`default_nettype none
module ebv_combine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire ebv_pkg::bundle_t  din,
  output logic                   valid,
  output logic signed [15:0]     res [9]
);
  localparam int TW = ebv_pkg::TW;
  localparam int PW = ebv_pkg::PW;
  localparam int QW = ebv_pkg::QW;
  localparam int HW = PW - TW;

  logic [3:0] v;

  // stage 1: quadrant fold and rounding to Q2.20
  logic signed [TW-1:0] sn1 [3];
  logic signed [TW-1:0] cs1 [3];
  logic signed [TW-1:0] sn_n [3];
  logic signed [TW-1:0] cs_n [3];
  logic signed [ebv_pkg::XW-1:0] cc, ss;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cc = din.rot[k].x;
      ss = din.rot[k].y;
      unique case (din.quad[k])
        2'd0: begin cc = din.rot[k].x;  ss = din.rot[k].y;  end
        2'd1: begin cc = -din.rot[k].y; ss = din.rot[k].x;  end
        2'd2: begin cc = -din.rot[k].x; ss = -din.rot[k].y; end
        default: begin cc = din.rot[k].y; ss = -din.rot[k].x; end
      endcase
      cs_n[k] = TW'((cc + ebv_pkg::XW'(512)) >>> 10);
      sn_n[k] = TW'((ss + ebv_pkg::XW'(512)) >>> 10);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sn1 <= sn_n;
      cs1 <= cs_n;
    end
  end

  // stage 2: pair products; index 0 pitch, 1 yaw, 2 roll
  logic signed [PW-1:0] cpcy2, cpsy2, srsp2, crsp2, crsy2, srsy2, crcy2, srcy2, srcp2, crcp2;
  logic signed [TW-1:0] sp2, cy2, sy2;

  always_ff @(posedge clk) begin
    if (advance) begin
      cpcy2 <= cs1[0] * cs1[1];
      cpsy2 <= cs1[0] * sn1[1];
      srsp2 <= sn1[2] * sn1[0];
      crsp2 <= cs1[2] * sn1[0];
      crsy2 <= cs1[2] * sn1[1];
      srsy2 <= sn1[2] * sn1[1];
      crcy2 <= cs1[2] * cs1[1];
      srcy2 <= sn1[2] * cs1[1];
      srcp2 <= sn1[2] * cs1[0];
      crcp2 <= cs1[2] * cs1[0];
      sp2   <= sn1[0];
      cy2   <= cs1[1];
      sy2   <= sn1[1];
    end
  end

  // stage 3: triple products split into high and low partials
  logic signed [PW-1:0]   hi3 [4];
  logic signed [PW:0]     lo3 [4];
  logic signed [PW-1:0]   cpcy3, cpsy3, crsy3, srsy3, crcy3, srcy3, srcp3, crcp3;
  logic signed [TW-1:0]   sp3;
  logic signed [HW-1:0]   ahi, bhi;
  logic signed [TW:0]     alo, blo;

  always_comb begin
    ahi = srsp2[PW-1:TW];
    bhi = crsp2[PW-1:TW];
    alo = $signed({1'b0, srsp2[TW-1:0]});
    blo = $signed({1'b0, crsp2[TW-1:0]});
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hi3[0] <= ahi * cy2;
      lo3[0] <= alo * cy2;
      hi3[1] <= ahi * sy2;
      lo3[1] <= alo * sy2;
      hi3[2] <= bhi * cy2;
      lo3[2] <= blo * cy2;
      hi3[3] <= bhi * sy2;
      lo3[3] <= blo * sy2;
      cpcy3 <= cpcy2;
      cpsy3 <= cpsy2;
      crsy3 <= crsy2;
      srsy3 <= srsy2;
      crcy3 <= crcy2;
      srcy3 <= srcy2;
      srcp3 <= srcp2;
      crcp3 <= crcp2;
      sp3   <= sp2;
    end
  end

  // stage 4: full Q.60 components
  logic signed [QW-1:0] t [4];
  logic signed [QW-1:0] q_n [9];
  logic signed [QW-1:0] q4 [9];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t[k] = (QW'(hi3[k]) <<< TW) + QW'(lo3[k]);
    end
    q_n[0] = QW'(cpcy3) <<< 20;
    q_n[1] = QW'(cpsy3) <<< 20;
    q_n[2] = -(QW'(sp3) <<< 40);
    q_n[3] = -t[0] + (QW'(crsy3) <<< 20);
    q_n[4] = -t[1] - (QW'(crcy3) <<< 20);
    q_n[5] = -(QW'(srcp3) <<< 20);
    q_n[6] = t[2] + (QW'(srsy3) <<< 20);
    q_n[7] = t[3] - (QW'(srcy3) <<< 20);
    q_n[8] = QW'(crcp3) <<< 20;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q4 <= q_n;
    end
  end

  // stage 5: round to Q1.15 and saturate
  logic signed [QW-45:0] r [9];
  logic signed [15:0]    res_n [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      r[k] = (QW-44)'((q4[k] + (QW'(1) <<< 44)) >>> 45);
      if (r[k] > (QW-44)'(32767)) begin
        res_n[k] = 16'sh7FFF;
      end else if (r[k] < -(QW-44)'(32768)) begin
        res_n[k] = 16'sh8000;
      end else begin
        res_n[k] = r[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else if (advance) begin
      v     <= {v[2:0], din.valid};
      valid <= v[3];
    end
  end
endmodule
`default_nettype wire

// ===== sv/euler_angles_to_basis_vectors_top.sv =====
// Euler angles (pitch, yaw, roll; 65536 units per turn) to forward, right and
// up unit vectors in signed Q1.15. Fully pipelined: one item per cycle while the
// output is taken, through the front quadrant-reduction register, the row of
// CORDIC rotation cells and then the fold, product and rounding stages.
// The whole pipeline holds while the output item is not taken.
`default_nettype none
`include "assert_macros.svh"
module euler_angles_to_basis_vectors_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] pitch_angle,
  input  wire logic signed [15:0] yaw_angle,
  input  wire logic signed [15:0] roll_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      forward_x,
  output logic signed [15:0]      forward_y,
  output logic signed [15:0]      forward_z,
  output logic signed [15:0]      right_x,
  output logic signed [15:0]      right_y,
  output logic signed [15:0]      right_z,
  output logic signed [15:0]      up_x,
  output logic signed [15:0]      up_y,
  output logic signed [15:0]      up_z
);
  localparam int N = ebv_pkg::STAGES;

  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // front stage: quadrant reduction
  ebv_pkg::bundle_t front_n, front;
  ebv_pkg::bundle_t chain [N+1];
  logic [15:0] ang [3];
  logic [31:0] phase, d;
  logic [1:0]  q;

  always_comb begin
    ang[0] = pitch_angle;
    ang[1] = yaw_angle;
    ang[2] = roll_angle;
    front_n.valid = in_valid;
    for (int k = 0; k < 3; k++) begin
      phase = {ang[k], 16'h0} & ebv_pkg::PHASE_KEEP;
      q     = 2'((phase + 32'h20000000) >> 30);
      d     = phase - {q, 30'h0};
      front_n.quad[k]  = q;
      front_n.rot[k].x = ebv_pkg::CORDIC_GAIN;
      front_n.rot[k].y = '0;
      front_n.rot[k].z = ebv_pkg::ZW'($signed(d));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      front.rot  <= front_n.rot;
      front.quad <= front_n.quad;
    end
    if (rst) begin
      front.valid <= 1'b0;
    end else if (advance) begin
      front.valid <= front_n.valid;
    end
  end

  assign chain[0] = front;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ebv_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .stage   (ebv_pkg::IDX_W'(i)),
      .din     (chain[i]),
      .dout    (chain[i+1])
    );
  end

  logic signed [15:0] res [9];

  ebv_combine u_combine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .din     (chain[N]),
    .valid   (out_valid),
    .res     (res)
  );

  assign forward_x = res[0];
  assign forward_y = res[1];
  assign forward_z = res[2];
  assign right_x   = res[3];
  assign right_y   = res[4];
  assign right_z   = res[5];
  assign up_x      = res[6];
  assign up_y      = res[7];
  assign up_z      = res[8];

  `EBV_ASSERT(a_stall_needs_item, clk, rst, !in_ready |-> out_valid, "stall without output item")
  `EBV_ASSERT(a_item_held, clk, rst, out_valid && !out_ready |=> out_valid, "output item dropped")
  `EBV_ASSERT_RST(a_reset_clears, clk, rst |=> !out_valid && !front.valid, "reset left items")
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  localparam int LATENCY = 1 + ebv_pkg::STAGES + 5;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } basis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] pitch_angle = '0, yaw_angle = '0, roll_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] forward_x, forward_y, forward_z;
  logic signed [15:0] right_x, right_y, right_z;
  logic signed [15:0] up_x, up_y, up_z;

  basis_t expected_basis[$];
  int errors = 0;
  int items_sent = 0;
  int vectors_checked = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stall_enable = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  euler_angles_to_basis_vectors_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z)
  );

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sine/cosine of a binary angle, both in Q2.20
  function automatic void angle_sincos(logic [15:0] ang, output longint sn,
                                       output longint cs);
    logic [31:0] phase, resid;
    logic [1:0] quad;
    longint x, y, z, nx, c, s;
    phase = {ang, 16'h0} & ebv_pkg::PHASE_KEEP;
    quad = 2'((phase + 32'h20000000) >> 30);
    resid = phase - ({30'd0, quad} << 30);
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < ebv_pkg::STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(ebv_pkg::atan_entry(ebv_pkg::IDX_W'(i)));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(ebv_pkg::atan_entry(ebv_pkg::IDX_W'(i)));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    sn = floor_shift(s + 512, 10);
    cs = floor_shift(c + 512, 10);
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    longint r;
    r = floor_shift(v + (longint'(1) << 44), 45);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic basis_t orientation_basis(logic [15:0] p, logic [15:0] yw,
                                               logic [15:0] r);
    longint sp, cp, sy, cy, sr, cr;
    longint k20, k40;
    basis_t b;
    k20 = longint'(1) << 20;
    k40 = longint'(1) << 40;
    angle_sincos(p, sp, cp);
    angle_sincos(yw, sy, cy);
    angle_sincos(r, sr, cr);
    b.fx = round_q15(cp * cy * k20);
    b.fy = round_q15(cp * sy * k20);
    b.fz = round_q15(-sp * k40);
    b.rx = round_q15(-(sr * sp * cy) + cr * sy * k20);
    b.ry = round_q15(-(sr * sp * sy) - cr * cy * k20);
    b.rz = round_q15(-(sr * cp) * k20);
    b.ux = round_q15(cr * sp * cy + sr * sy * k20);
    b.uy = round_q15(cr * sp * sy - sr * cy * k20);
    b.uz = round_q15(cr * cp * k20);
    return b;
  endfunction

  task automatic compare_field(string name, logic signed [15:0] exp_v,
                               logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver: random stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (stall_enable) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      vectors_checked++;
      if (expected_basis.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        basis_t e;
        e = expected_basis.pop_front();
        compare_field("forward_x", e.fx, forward_x);
        compare_field("forward_y", e.fy, forward_y);
        compare_field("forward_z", e.fz, forward_z);
        compare_field("right_x", e.rx, right_x);
        compare_field("right_y", e.ry, right_y);
        compare_field("right_z", e.rz, right_z);
        compare_field("up_x", e.ux, up_x);
        compare_field("up_y", e.uy, up_y);
        compare_field("up_z", e.uz, up_z);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("euler_angles_to_basis_vectors_top verification failed");
      $finish;
    end
  end

  // valid stays high across back-to-back items; gaps lower it once
  task automatic send_angles(logic [15:0] p, logic [15:0] yw, logic [15:0] r);
    in_valid <= 1'b1;
    pitch_angle <= p;
    yaw_angle <= yw;
    roll_angle <= r;
    do @(posedge clk); while (!in_ready);
    expected_basis.push_back(orientation_basis(p, yw, r));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (expected_basis.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_angles();
    logic [15:0] edges[10];
    edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000,
              16'h2000, 16'hE000, 16'h0001, 16'h5555};
    for (int i = 0; i < 10; i++) send_angles(edges[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_angles(16'h0000, edges[i], edges[9 - i]);
    // full-scale outputs and quadrant folds together
    send_angles(16'h0000, 16'h0000, 16'h4000);
    send_angles(16'h4000, 16'h4000, 16'h4000);
    send_angles(16'hC000, 16'h8000, 16'hC000);
    send_angles(16'h8000, 16'h7FFF, 16'h8000);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'hAAAA, 16'h5555, 16'h2001);
    drain_results();
  endtask

  task automatic test_random_bursts(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_angles(16'($urandom_range(0, 8) << 13), 16'($urandom_range(0, 8) << 13),
                      16'($urandom));
        else
          send_angles(16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    join
    drain_results();
  endtask

  task automatic test_full_rate();
    stall_enable = 1'b0;
    for (int i = 0; i < 60; i++) send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    drain_results();
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_angles();
    test_random_bursts(200);
    test_backpressure();
    test_full_rate();
    test_random_bursts(200);
    drain_results();
    repeat (LATENCY + 5) @(negedge clk);
    $display("Sent %0d angle triples; checked %0d basis vector sets, incl. stalls,",
             items_sent, vectors_checked);
    $display("a long output hold-off and a full-rate stretch.");
    if (errors == 0 && expected_basis.size() == 0)
      $display("euler_angles_to_basis_vectors_top verification clean");
    else
      $display("euler_angles_to_basis_vectors_top verification failed");
    $finish;
  end
endmodule
